// ===== design/utlg_pkg.sv =====
// Shared types and constants of the ultrasonic tank level gauge.
// Used by the channel interfaces, the serial arithmetic unit and the top level.
package utlg_pkg;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ECHO_W   = 15;
	localparam int unsigned DIST_W   = 13;
	localparam int unsigned LEVEL_W  = 14;
	localparam int unsigned VOL_W    = 17;
	localparam int unsigned OFFS_W   = 10;
	localparam int unsigned TOL_W    = 9;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 17;

	// Distance in sixteenths of a millimetre
	localparam int unsigned D16_W = 17;

	// Serial multiply-divide operand widths: q = (a * b + c) / d
	localparam int unsigned MD_A_W   = 18;
	localparam int unsigned MD_B_W   = 14;
	localparam int unsigned MD_C_W   = 14;
	localparam int unsigned MD_D_W   = 17;
	localparam int unsigned MD_P_W   = MD_A_W + MD_B_W;
	localparam int unsigned MD_Q_W   = MD_P_W + 1;

	// Frame and range constants
	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFF;
	localparam logic [11:0]       ECHO_SCALE = 12'd2810;
	localparam logic [19:0]       MIN_MM     = 20'd20;
	localparam logic [19:0]       MAX_MM     = 20'd4000;
	localparam logic [D16_W-1:0]  MIN_D16    = 17'd320;
	localparam logic [D16_W-1:0]  MAX_D16    = 17'd64000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRICT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MM   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOL      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 4'd7;

	// Register reset values
	localparam logic [DIST_W-1:0]  RST_EMPTY    = 13'd1850;
	localparam logic [DIST_W-1:0]  RST_FULL     = 13'd200;
	localparam logic [TOL_W-1:0]   RST_TOL      = 9'd10;
	localparam logic [LEVEL_W-1:0] RST_HEIGHT   = 14'd1650;
	localparam logic [VOL_W-1:0]   RST_CAPACITY = 17'd1200;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_TIMEOUT  = 2'd3
	} status_t;

	// Frame parser phases
	typedef enum logic [1:0] {
		PH_SYNC = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2,
		PH_CHK  = 2'd3
	} phase_t;

	// Request and response of the serial multiply-divide unit
	typedef struct packed {
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_C_W-1:0] c;
		logic [MD_D_W-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [MD_Q_W-1:0] quot;
	} md_rsp_t;

endpackage

// ===== design/utlg_if.sv =====
// Channel interfaces of the ultrasonic tank level gauge: input item, result, register write.
// Depends on utlg_pkg for the field widths.
interface utlg_item_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [utlg_pkg::BYTE_W-1:0]  byte_value;
	logic [utlg_pkg::ECHO_W-1:0]  echo_us;

	modport source (output valid, kind, byte_value, echo_us, input ready);
	modport sink   (input valid, kind, byte_value, echo_us, output ready);
endinterface

interface utlg_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [utlg_pkg::LEVEL_W-1:0]  level_mm;
	logic [utlg_pkg::VOL_W-1:0]    volume_centi;
	logic [utlg_pkg::DIST_W-1:0]   distance_mm;
	logic                          has_reading;

	modport source (output valid, status, level_mm, volume_centi, distance_mm, has_reading,
		input ready);
	modport sink   (input valid, status, level_mm, volume_centi, distance_mm, has_reading,
		output ready);
endinterface

interface utlg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [utlg_pkg::CFG_IDX_W-1:0]  index;
	logic [utlg_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ultrasonic_tank_level_gauge.sv =====
// Top level of the ultrasonic tank level gauge: frame parser, echo scaling, level and volume.
// Depends on utlg_pkg, the channel interfaces in utlg_if and the serial unit utlg_muldiv.
//
//  channel  role    handshake     payload
//  -------  ------  ------------  -----------------------------------------------------
//  item     sink    valid/ready   kind, byte_value, echo_us
//  result   source  valid/ready   status, level_mm, volume_centi, distance_mm, has_reading
//  cfg      sink    valid/ready   index, data (ready is always high)
//
// A byte that closes no frame passes only through the evaluate state. A result takes at most one
// multiply-divide when the level snaps to an edge or nothing is accepted and up to two when the level
// is interpolated: each multiply-divide on the shared bit-serial unit runs a multiply, an add and
// a divide phase. Reset puts the parser, kept level and distance and registers back to reset values.
// The result register holds a finished transaction while the next item is taken; a new result
// waits in the emit state until that register is free.
module ultrasonic_tank_level_gauge (
	input  logic                 clk,
	input  logic                 arst_n,
	utlg_item_if.sink            item,
	utlg_result_if.source        result,
	utlg_cfg_if.sink             cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MAP,
		S_LVL,
		S_VOL,
		S_VWAIT,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                             strict_q;
	logic                             raw_mm_q;
	logic [utlg_pkg::DIST_W-1:0]      empty_q;
	logic [utlg_pkg::DIST_W-1:0]      full_q;
	logic signed [utlg_pkg::OFFS_W-1:0] offset_q;
	logic [utlg_pkg::TOL_W-1:0]       tol_q;
	logic [utlg_pkg::LEVEL_W-1:0]     height_q;
	logic [utlg_pkg::VOL_W-1:0]       cap_q;

	// Block state
	utlg_pkg::phase_t                 phase_q;
	logic [utlg_pkg::BYTE_W-1:0]      high_q;
	logic [utlg_pkg::BYTE_W-1:0]      low_q;
	logic [utlg_pkg::LEVEL_W-1:0]     level_q;
	logic [utlg_pkg::DIST_W-1:0]      last_dist_q;
	logic                             seen_q;

	// Latched item and work registers
	logic                             kind_q;
	logic [utlg_pkg::BYTE_W-1:0]      byte_q;
	logic [utlg_pkg::ECHO_W-1:0]      echo_q;
	logic [utlg_pkg::D16_W-1:0]       d16_q;
	utlg_pkg::status_t                status_q;
	logic [utlg_pkg::VOL_W-1:0]       vol_q;

	// Result register
	logic                             res_valid_q;
	logic [1:0]                       res_status_q;
	logic [utlg_pkg::LEVEL_W-1:0]     res_level_q;
	logic [utlg_pkg::VOL_W-1:0]       res_vol_q;
	logic [utlg_pkg::DIST_W-1:0]      res_dist_q;
	logic                             res_seen_q;

	// Serial arithmetic unit
	logic                             md_start;
	utlg_pkg::md_req_t                md_req;
	utlg_pkg::md_rsp_t                md_rsp;

	utlg_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// ---------------------------------------------------------------- frame and echo checks
	logic [8:0]                       chk_sum;
	logic [utlg_pkg::BYTE_W-1:0]      chk_plain;
	logic [utlg_pkg::BYTE_W-1:0]      chk_sync;
	logic                             chk_fail;
	logic [15:0]                      frame_dist;
	logic [19:0]                      frame_mm;
	logic                             frame_in_range;
	logic [26:0]                      echo_prod;
	logic [utlg_pkg::D16_W-1:0]       echo_d16;
	logic                             echo_in_range;

	assign chk_sum   = {1'b0, high_q} + {1'b0, low_q};
	assign chk_plain = chk_sum[7:0];
	assign chk_sync  = chk_sum[7:0] + utlg_pkg::SYNC_BYTE;
	assign chk_fail  = strict_q && (byte_q != chk_sync) && (byte_q != chk_plain);

	// Centimetre frames scale by ten as 8x + 2x
	assign frame_dist     = {high_q, low_q};
	assign frame_mm       = raw_mm_q ? 20'(frame_dist)
		: (20'({frame_dist, 3'b000}) + 20'({frame_dist, 1'b0}));
	assign frame_in_range = (frame_mm >= utlg_pkg::MIN_MM) && (frame_mm <= utlg_pkg::MAX_MM);

	// Echo time to sixteenths of a mm: us * 2810 / 1024
	assign echo_prod     = 27'(echo_q) * 27'(utlg_pkg::ECHO_SCALE);
	assign echo_d16      = echo_prod[26:10];
	assign echo_in_range = (echo_d16 >= utlg_pkg::MIN_D16) && (echo_d16 <= utlg_pkg::MAX_D16);

	// ---------------------------------------------------------------- level mapping
	logic signed [18:0]               d_adj;
	logic signed [18:0]               full_edge;
	logic signed [18:0]               empty_edge;
	logic [14:0]                      empty_tol;
	logic [utlg_pkg::DIST_W-1:0]      span;
	logic [utlg_pkg::D16_W-1:0]       span16;
	logic [utlg_pkg::D16_W-1:0]       num16;
	logic [utlg_pkg::LEVEL_W-1:0]     lv_clamped;

	// All in sixteenths of a mm
	assign d_adj      = $signed({2'b00, d16_q}) + $signed({{5{offset_q[utlg_pkg::OFFS_W-1]}},
		offset_q, 4'b0000});
	assign full_edge  = $signed({1'b0, (14'(full_q) + 14'(tol_q)), 4'b0000});
	assign empty_tol  = {2'b00, empty_q} - 15'(tol_q);
	assign empty_edge = $signed({empty_tol, 4'b0000});
	assign span       = (empty_q > full_q) ? (empty_q - full_q) : utlg_pkg::DIST_W'(1);
	assign span16     = {span, 4'b0000};
	// Only used strictly between the edges, where 0 < d_adj < 16 * empty
	assign num16      = {empty_q, 4'b0000} - d_adj[utlg_pkg::D16_W-1:0];
	assign lv_clamped = (level_q > height_q) ? height_q : level_q;

	always_comb begin
		md_req   = '0;
		md_start = 1'b0;
		if (state_q == S_VOL) begin
			// Volume: (2 * cap * level + h) / (2 * h)
			md_req.a = {cap_q, 1'b0};
			md_req.b = lv_clamped;
			md_req.c = height_q;
			md_req.d = utlg_pkg::MD_D_W'({height_q, 1'b0});
			md_start = (height_q != '0);
		end else begin
			// Level: num * h / (16 * span)
			md_req.a = utlg_pkg::MD_A_W'(num16);
			md_req.b = height_q;
			md_req.c = '0;
			md_req.d = span16;
			md_start = (state_q == S_MAP) && !(d_adj <= full_edge) && !(d_adj >= empty_edge);
		end
	end

	// ---------------------------------------------------------------- configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			raw_mm_q <= 1'b1;
			empty_q  <= utlg_pkg::RST_EMPTY;
			full_q   <= utlg_pkg::RST_FULL;
			offset_q <= '0;
			tol_q    <= utlg_pkg::RST_TOL;
			height_q <= utlg_pkg::RST_HEIGHT;
			cap_q    <= utlg_pkg::RST_CAPACITY;
		end else if (cfg.valid) begin
			case (cfg.index)
				utlg_pkg::REG_STRICT:   strict_q <= cfg.data[0];
				utlg_pkg::REG_RAW_MM:   raw_mm_q <= cfg.data[0];
				utlg_pkg::REG_EMPTY:    empty_q  <= cfg.data[utlg_pkg::DIST_W-1:0];
				utlg_pkg::REG_FULL:     full_q   <= cfg.data[utlg_pkg::DIST_W-1:0];
				utlg_pkg::REG_OFFSET:   offset_q <= $signed(cfg.data[utlg_pkg::OFFS_W-1:0]);
				utlg_pkg::REG_TOL:      tol_q    <= cfg.data[utlg_pkg::TOL_W-1:0];
				utlg_pkg::REG_HEIGHT:   height_q <= cfg.data[utlg_pkg::LEVEL_W-1:0];
				utlg_pkg::REG_CAPACITY: cap_q    <= cfg.data[utlg_pkg::VOL_W-1:0];
				default: ; // unknown index: drop the write
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign item.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_q <= item.kind;
			byte_q <= item.byte_value;
			echo_q <= item.echo_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= utlg_pkg::PH_SYNC;
			high_q       <= '0;
			low_q        <= '0;
			level_q      <= '0;
			last_dist_q  <= utlg_pkg::RST_EMPTY;
			seen_q       <= 1'b0;
			d16_q        <= '0;
			status_q     <= utlg_pkg::ST_OK;
			vol_q        <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= '0;
			res_level_q  <= '0;
			res_vol_q    <= '0;
			res_dist_q   <= '0;
			res_seen_q   <= 1'b0;
		end else begin
			// Drop the result once the sink takes it; the emit state reloads it itself
			if (result.ready && state_q != S_EMIT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					if (!kind_q) begin
						if (byte_q == utlg_pkg::SYNC_BYTE) begin
							// A sync byte restarts the frame from any phase
							phase_q <= utlg_pkg::PH_HIGH;
						end else begin
							case (phase_q)
								utlg_pkg::PH_HIGH: begin
									high_q  <= byte_q;
									phase_q <= utlg_pkg::PH_LOW;
								end
								utlg_pkg::PH_LOW: begin
									low_q   <= byte_q;
									phase_q <= utlg_pkg::PH_CHK;
								end
								utlg_pkg::PH_CHK: begin
									phase_q <= utlg_pkg::PH_SYNC;
									if (chk_fail) begin
										status_q <= utlg_pkg::ST_CHECKSUM;
										state_q  <= S_VOL;
									end else if (!frame_in_range) begin
										status_q <= utlg_pkg::ST_RANGE;
										state_q  <= S_VOL;
									end else begin
										d16_q   <= {1'b0, frame_mm[11:0], 4'b0000};
										state_q <= S_MAP;
									end
								end
								default: ; // waiting for sync: ignore the byte
							endcase
						end
					end else if (echo_q == '0) begin
						status_q <= utlg_pkg::ST_TIMEOUT;
						state_q  <= S_VOL;
					end else if (!echo_in_range) begin
						status_q <= utlg_pkg::ST_RANGE;
						state_q  <= S_VOL;
					end else begin
						d16_q   <= echo_d16;
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					status_q    <= utlg_pkg::ST_OK;
					last_dist_q <= d16_q[utlg_pkg::D16_W-1:4];
					seen_q      <= 1'b1;
					if (d_adj <= full_edge) begin
						level_q <= height_q;
						state_q <= S_VOL;
					end else if (d_adj >= empty_edge) begin
						level_q <= '0;
						state_q <= S_VOL;
					end else begin
						state_q <= S_LVL;
					end
				end
				S_LVL: begin
					if (md_rsp.done) begin
						level_q <= (md_rsp.quot > utlg_pkg::MD_Q_W'(height_q)) ? height_q
							: md_rsp.quot[utlg_pkg::LEVEL_W-1:0];
						state_q <= S_VOL;
					end
				end
				S_VOL: begin
					if (height_q == '0) begin
						vol_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_VWAIT;
					end
				end
				S_VWAIT: begin
					if (md_rsp.done) begin
						vol_q   <= md_rsp.quot[utlg_pkg::VOL_W-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// Hold until the result register is free
					if (!res_valid_q || result.ready) begin
						res_valid_q  <= 1'b1;
						res_status_q <= status_q;
						res_level_q  <= level_q;
						res_vol_q    <= vol_q;
						res_dist_q   <= last_dist_q;
						res_seen_q   <= seen_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.status       = res_status_q;
	assign result.level_mm     = res_level_q;
	assign result.volume_centi = res_vol_q;
	assign result.distance_mm  = res_dist_q;
	assign result.has_reading  = res_seen_q;

`ifndef SYNTHESIS
	// The serial unit is started only when it is free
	assert property (@(posedge clk) disable iff (!arst_n) md_start |-> !md_rsp.busy)
		else $error("muldiv started while busy");

	// An accepted measurement always reports a reading
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == utlg_pkg::ST_OK)) |-> result.has_reading)
		else $error("accepted result without reading");

	// Rounded volume never exceeds the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.volume_centi <= cap_q))
		else $error("volume above capacity");

	// A low byte moves the parser to the checksum phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && !kind_q && byte_q != utlg_pkg::SYNC_BYTE
			&& phase_q == utlg_pkg::PH_LOW) |=> (phase_q == utlg_pkg::PH_CHK))
		else $error("parser missed checksum phase");
`endif

endmodule

// ===== design/utlg_muldiv.sv =====
// Bit-serial unit computing q = floor((a * b + c) / d): shift-add multiply, then restoring divide.
// Depends on utlg_pkg for the request and response structs.
module utlg_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  utlg_pkg::md_req_t req,
	output utlg_pkg::md_rsp_t rsp
);

	localparam int unsigned MUL_CNT_W = $clog2(utlg_pkg::MD_B_W);
	localparam int unsigned DIV_CNT_W = $clog2(utlg_pkg::MD_Q_W);
	localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(utlg_pkg::MD_B_W - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(utlg_pkg::MD_Q_W - 1);

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_ADD,
		MD_DIV
	} md_state_t;

	md_state_t                      state_q;
	logic [MUL_CNT_W-1:0]           mcnt_q;
	logic [DIV_CNT_W-1:0]           dcnt_q;
	logic                           done_q;
	logic [utlg_pkg::MD_A_W-1:0]    a_q;
	logic [utlg_pkg::MD_C_W-1:0]    c_q;
	logic [utlg_pkg::MD_D_W-1:0]    d_q;
	logic [utlg_pkg::MD_A_W-1:0]    hi_q;
	logic [utlg_pkg::MD_B_W-1:0]    lo_q;
	logic [utlg_pkg::MD_Q_W-1:0]    dvd_q;
	logic [utlg_pkg::MD_D_W-1:0]    rem_q;

	logic [utlg_pkg::MD_A_W:0]      psum;
	logic [utlg_pkg::MD_D_W:0]      trial;
	logic                           qbit;
	logic [utlg_pkg::MD_D_W:0]      tdiff;

	// One multiplier bit per cycle: add a into the high half, shift right
	assign psum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
	// One quotient bit per cycle
	assign trial = {rem_q, dvd_q[utlg_pkg::MD_Q_W-1]};
	assign qbit  = (trial >= {1'b0, d_q});
	assign tdiff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			mcnt_q  <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						state_q <= MD_MUL;
						mcnt_q  <= '0;
					end
				end
				MD_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MUL_LAST) begin
						state_q <= MD_ADD;
					end
				end
				MD_ADD: begin
					state_q <= MD_DIV;
					dcnt_q  <= '0;
				end
				MD_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIV_LAST) begin
						state_q <= MD_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					a_q  <= req.a;
					c_q  <= req.c;
					d_q  <= req.d;
					hi_q <= '0;
					lo_q <= req.b;
				end
			end
			MD_MUL: begin
				hi_q <= psum[utlg_pkg::MD_A_W:1];
				lo_q <= {psum[0], lo_q[utlg_pkg::MD_B_W-1:1]};
			end
			MD_ADD: begin
				dvd_q <= {1'b0, hi_q, lo_q} + utlg_pkg::MD_Q_W'(c_q);
				rem_q <= '0;
			end
			MD_DIV: begin
				rem_q <= qbit ? tdiff[utlg_pkg::MD_D_W-1:0] : trial[utlg_pkg::MD_D_W-1:0];
				dvd_q <= {dvd_q[utlg_pkg::MD_Q_W-2:0], qbit};
			end
			default: ;
		endcase
	end

	assign rsp.busy = (state_q != MD_IDLE);
	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule

// ===== verif/ultrasonic_tank_level_gauge_checker.sv =====
// Checker of the ultrasonic tank level gauge: watches the item, result and register channels,
// predicts every result from its own copy of the gauge state and compares field by field.
// Depends on utlg_pkg and the channel interfaces in utlg_if.
module ultrasonic_tank_level_gauge_checker (
	input  logic        clk,
	input  logic        arst_n,
	utlg_item_if        item,
	utlg_result_if      result,
	utlg_cfg_if         cfg,
	output int unsigned mismatch_total,
	output int unsigned readings_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import utlg_pkg::*;

	typedef struct {
		status_t              status;
		logic [LEVEL_W-1:0]   level_mm;
		logic [VOL_W-1:0]     volume_centi;
		logic [DIST_W-1:0]    distance_mm;
		logic                 has_reading;
	} gauge_reading_t;

	gauge_reading_t expected_readings[$];

	// register copy
	logic                      strict_chk;
	logic                      raw_mm;
	logic [DIST_W-1:0]         empty_mm;
	logic [DIST_W-1:0]         full_mm;
	logic signed [OFFS_W-1:0]  offset_mm;
	logic [TOL_W-1:0]          tol_mm;
	logic [LEVEL_W-1:0]        height_mm;
	logic [VOL_W-1:0]          capacity;

	// parser and kept measurement
	phase_t              phase;
	logic [BYTE_W-1:0]   high_b;
	logic [BYTE_W-1:0]   low_b;
	logic [LEVEL_W-1:0]  kept_level;
	logic [DIST_W-1:0]   kept_dist;
	logic                seen;

	// distance in sixteenths of a mm to level, with edge snapping and interpolation
	function automatic logic [LEVEL_W-1:0] predict_level(longint d16);
		longint span, d, num, lv;
		span = longint'(empty_mm) - longint'(full_mm);
		if (span < 1)
			span = 1;
		d = d16 + 16 * longint'(offset_mm);
		if (d <= 16 * (longint'(full_mm) + longint'(tol_mm)))
			return height_mm;
		if (d >= 16 * (longint'(empty_mm) - longint'(tol_mm)))
			return '0;
		num = 16 * longint'(empty_mm) - d;
		if (num < 0)
			num = 0;
		lv = num * longint'(height_mm) / (16 * span);
		if (lv > longint'(height_mm))
			lv = longint'(height_mm);
		return LEVEL_W'(lv);
	endfunction

	// round half up of level / height * capacity
	function automatic logic [VOL_W-1:0] predict_volume();
		longint unsigned lv, h;
		lv = kept_level;
		h = height_mm;
		if (lv > h)
			lv = h;
		if (h == 0)
			return '0;
		return VOL_W'((2 * lv * capacity + h) / (2 * h));
	endfunction

	function automatic void note_reading(int unsigned d16);
		kept_dist = DIST_W'(d16 >> 4);
		kept_level = predict_level(longint'(d16));
		seen = 1'b1;
	endfunction

	function automatic void queue_reading(status_t st);
		gauge_reading_t r;
		r.status = st;
		r.level_mm = kept_level;
		r.volume_centi = predict_volume();
		r.distance_mm = kept_dist;
		r.has_reading = seen;
		expected_readings.push_back(r);
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] gauge mismatch: %s", $realtime, msg);
		mismatch_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int unsigned sum, raw_dist, mm, d16;
		gauge_reading_t want;
		if (!arst_n) begin
			strict_chk = 1'b0;
			raw_mm = 1'b1;
			empty_mm = RST_EMPTY;
			full_mm = RST_FULL;
			offset_mm = '0;
			tol_mm = RST_TOL;
			height_mm = RST_HEIGHT;
			capacity = RST_CAPACITY;
			phase = PH_SYNC;
			high_b = '0;
			low_b = '0;
			kept_level = '0;
			kept_dist = RST_EMPTY;
			seen = 1'b0;
			expected_readings.delete();
			readings_due <= 0;
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				case (cfg.index)
					REG_STRICT:   strict_chk = cfg.data[0];
					REG_RAW_MM:   raw_mm = cfg.data[0];
					REG_EMPTY:    empty_mm = cfg.data[DIST_W-1:0];
					REG_FULL:     full_mm = cfg.data[DIST_W-1:0];
					REG_OFFSET:   offset_mm = cfg.data[OFFS_W-1:0];
					REG_TOL:      tol_mm = cfg.data[TOL_W-1:0];
					REG_HEIGHT:   height_mm = cfg.data[LEVEL_W-1:0];
					REG_CAPACITY: capacity = cfg.data[VOL_W-1:0];
					default: ;
				endcase
			end

			if (item.valid === 1'b1 && item.ready === 1'b1) begin
				if (item.kind == 1'b0) begin
					if (item.byte_value == SYNC_BYTE) begin
						phase = PH_HIGH;
					end else begin
						case (phase)
							PH_HIGH: begin
								high_b = item.byte_value;
								phase = PH_LOW;
							end
							PH_LOW: begin
								low_b = item.byte_value;
								phase = PH_CHK;
							end
							PH_CHK: begin
								phase = PH_SYNC;
								sum = high_b + low_b;
								raw_dist = {high_b, low_b};
								mm = raw_mm ? raw_dist : raw_dist * 10;
								if (strict_chk && item.byte_value != 8'(sum + SYNC_BYTE)
										&& item.byte_value != 8'(sum)) begin
									queue_reading(ST_CHECKSUM);
								end else if (mm < MIN_MM || mm > MAX_MM) begin
									queue_reading(ST_RANGE);
								end else begin
									note_reading(mm << 4);
									queue_reading(ST_OK);
								end
							end
							default: ;
						endcase
					end
				end else begin
					if (item.echo_us == '0) begin
						queue_reading(ST_TIMEOUT);
					end else begin
						d16 = (32'(item.echo_us) * 32'(ECHO_SCALE)) >> 10;
						if (d16 < MIN_D16 || d16 > MAX_D16) begin
							queue_reading(ST_RANGE);
						end else begin
							note_reading(d16);
							queue_reading(ST_OK);
						end
					end
				end
			end

			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result status %0d level %0d with nothing pending",
						result.status, result.level_mm));
				end else begin
					want = expected_readings.pop_front();
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							result.status, want.status));
					if (result.level_mm !== want.level_mm)
						report_mismatch($sformatf("level_mm %0d, want %0d",
							result.level_mm, want.level_mm));
					if (result.volume_centi !== want.volume_centi)
						report_mismatch($sformatf("volume_centi %0d, want %0d",
							result.volume_centi, want.volume_centi));
					if (result.distance_mm !== want.distance_mm)
						report_mismatch($sformatf("distance_mm %0d, want %0d",
							result.distance_mm, want.distance_mm));
					if (result.has_reading !== want.has_reading)
						report_mismatch($sformatf("has_reading %0b, want %0b",
							result.has_reading, want.has_reading));
				end
			end
			readings_due <= expected_readings.size();
		end
	end

endmodule

// ===== verif/ultrasonic_tank_level_gauge_tb.sv =====
// Testbench top of the ultrasonic tank level gauge: clock, reset, item and register stimulus,
// result back-pressure and the verdict. Depends on utlg_pkg, utlg_if, the gauge RTL and
// ultrasonic_tank_level_gauge_checker, which does all prediction and comparison.
module ultrasonic_tank_level_gauge_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import utlg_pkg::*;

	localparam int     CLK_PERIOD_NS   = 4;
	localparam int     RESET_CYCLES    = 9;
	localparam int     MIXED_PHASES    = 7;
	localparam int     MIXED_ITEMS     = 270;
	// a byte that closes no frame may still be in flight after the last result
	localparam int     SETTLE_CYCLES   = 16;
	// an interpolated result is the slowest, with two multiply-divides
	localparam int     DRAIN_CYCLES    = 250;
	localparam int     HOLD_OFF_CYCLES = 600;
	localparam int     HOLD_OFF_PHASE  = 4;
	// slowest run: ~1950 items, each interpolated, plus the longest gaps on both sides, taken 4x
	localparam longint RUN_LIMIT_NS    = 4_000_000;
	localparam int     ECHO_MAX_US     = 30000;
	// shortest and longest echo widths whose distance lies inside 20..4000 mm
	localparam int     ECHO_FIRST_OK   = 117;
	localparam int     ECHO_LAST_OK    = 23322;

	typedef struct {
		bit          strict;
		bit          raw_mm;
		int unsigned empty_mm;
		int unsigned full_mm;
		int          offset_mm;
		int unsigned tol_mm;
		int unsigned height_mm;
		int unsigned capacity;
	} gauge_settings_t;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          idling;
	bit          hold_off_req;
	int unsigned mismatch_total;
	int unsigned readings_due;

	utlg_item_if   item_ch ();
	utlg_result_if result_ch ();
	utlg_cfg_if    cfg_ch ();

	ultrasonic_tank_level_gauge i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	ultrasonic_tank_level_gauge_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.result         (result_ch),
		.cfg            (cfg_ch),
		.mismatch_total (mismatch_total),
		.readings_due   (readings_due)
	);

	always #(CLK_PERIOD_NS / 2) clk = ~clk;

	// Offer one item and hold it until the transaction completes. The previous item stays
	// valid until here, so valid is only lowered when a gap is actually inserted.
	task automatic offer(input logic k, input logic [BYTE_W-1:0] b,
			input logic [ECHO_W-1:0] us);
		int gap;
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= k;
		item_ch.byte_value <= b;
		item_ch.echo_us    <= us;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	// the unused payload field carries random bits so that every bit toggles
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		offer(1'b0, b, ECHO_W'($urandom_range(0, ECHO_MAX_US)));
	endtask

	task automatic send_echo(input int unsigned us);
		offer(1'b1, BYTE_W'($urandom), ECHO_W'(us));
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] l,
			input logic [BYTE_W-1:0] chk);
		send_byte(SYNC_BYTE);
		send_byte(h);
		send_byte(l);
		send_byte(chk);
	endtask

	// Drop valid, wait for every predicted result to come back, then let a trailing
	// no-result byte finish before anything else touches the block.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (readings_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
	endtask

	// Write every register, then one index past the list, which the block must ignore.
	task automatic write_settings(input gauge_settings_t s);
		logic [OFFS_W-1:0] off_bits;
		off_bits = OFFS_W'(s.offset_mm);
		write_reg(REG_STRICT, CFG_DAT_W'(s.strict));
		write_reg(REG_RAW_MM, CFG_DAT_W'(s.raw_mm));
		write_reg(REG_EMPTY, CFG_DAT_W'(s.empty_mm));
		write_reg(REG_FULL, CFG_DAT_W'(s.full_mm));
		write_reg(REG_OFFSET, {{(CFG_DAT_W - OFFS_W){1'b0}}, off_bits});
		write_reg(REG_TOL, CFG_DAT_W'(s.tol_mm));
		write_reg(REG_HEIGHT, CFG_DAT_W'(s.height_mm));
		write_reg(REG_CAPACITY, CFG_DAT_W'(s.capacity));
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_CAPACITY) + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DAT_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic gauge_settings_t reset_settings();
		gauge_settings_t s;
		s.strict    = 1'b0;
		s.raw_mm    = 1'b1;
		s.empty_mm  = RST_EMPTY;
		s.full_mm   = RST_FULL;
		s.offset_mm = 0;
		s.tol_mm    = RST_TOL;
		s.height_mm = RST_HEIGHT;
		s.capacity  = RST_CAPACITY;
		return s;
	endfunction

	// Keep empty always above full so that interpolation gets exercised.
	function automatic gauge_settings_t random_settings();
		gauge_settings_t s;
		s.strict    = $urandom_range(0, 1);
		s.raw_mm    = $urandom_range(0, 1);
		s.full_mm   = $urandom_range(0, 2500);
		s.empty_mm  = s.full_mm + $urandom_range(50, 2500);
		if (s.empty_mm > 5000)
			s.empty_mm = 5000;
		s.offset_mm = int'($urandom_range(0, 1000)) - 500;
		s.tol_mm    = $urandom_range(0, 150);
		s.height_mm = $urandom_range(1, 10000);
		s.capacity  = $urandom_range(1, 100000);
		return s;
	endfunction

	// Mostly well-formed frames and echoes with random content; the rest is abandoned
	// frames and stray bytes. Stray bytes are not counted toward the budget.
	task automatic run_mixed(input int budget, input gauge_settings_t s);
		int          sent;
		int          pick;
		int          n;
		int unsigned raw_dist;
		logic [BYTE_W-1:0] h, l, chk;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				raw_dist = s.raw_mm ? $urandom_range(0, 4300) : $urandom_range(0, 430);
				if ($urandom_range(0, 9) == 0)
					raw_dist = $urandom_range(0, 16'hFFFF);
				h = raw_dist[15:8];
				l = raw_dist[7:0];
				case ($urandom_range(0, 2))
					0:       chk = h + l + SYNC_BYTE;
					1:       chk = h + l;
					default: chk = BYTE_W'($urandom);
				endcase
				send_frame(h, l, chk);
				sent += 4;
			end else if (pick < 80) begin
				n = $urandom_range(0, 19);
				if (n == 0)
					send_echo(0);
				else if (n < 4)
					send_echo($urandom_range(0, ECHO_MAX_US));
				else
					send_echo($urandom_range(ECHO_FIRST_OK, ECHO_LAST_OK));
				sent++;
			end else if (pick < 90) begin
				// abandon a frame part way; the next sync restarts the parser
				n = $urandom_range(0, 2);
				send_byte(SYNC_BYTE);
				repeat (n) send_byte(BYTE_W'($urandom));
				sent += 1 + n;
			end else begin
				send_byte(BYTE_W'($urandom));
			end
		end
	endtask

	// Result side: random stall bursts while idling is on, and one long hold-off on request
	// so that the result register and the emit state fill up and the item input stalls.
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		stall = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_OFF_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 13) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if the block hangs or drops a result.
	initial begin
		#(RUN_LIMIT_NS);
		$display("ultrasonic_tank_level_gauge verification failed");
		$finish;
	end

	initial begin
		gauge_settings_t s;
		int              phase_idx;
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.kind       <= 1'b0;
		item_ch.byte_value <= '0;
		item_ch.echo_us    <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		idling       = 1'b1;
		hold_off_req = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset settings. A timeout first: nothing accepted yet, so
		// the kept distance must still be the reset empty distance.
		send_echo(0);
		// stray byte while waiting for sync
		send_byte(8'h12);
		// 4000 mm, the far end of the range, lands beyond empty
		send_frame(8'h0F, 8'hA0, 8'h55);
		// echo range edges: 117 us is 20 mm and snaps to full, 23322 us is the last in range
		send_echo(ECHO_FIRST_OK);
		send_echo(ECHO_LAST_OK);
		send_echo(ECHO_LAST_OK + 1);
		send_echo(ECHO_MAX_US);
		// sync in the middle of a frame restarts it; 1000 mm interpolates
		send_byte(SYNC_BYTE);
		send_byte(8'h03);
		send_frame(8'h03, 8'hE8, 8'hAA);

		// strict checksum in centimetre mode: both checksum forms, a bad one, one frame past each range end
		s = reset_settings();
		s.strict = 1'b1;
		s.raw_mm = 1'b0;
		wait_idle();
		write_settings(s);
		send_frame(8'h00, 8'h64, 8'h63);
		send_frame(8'h00, 8'h64, 8'h64);
		send_frame(8'h00, 8'h64, 8'h00);
		send_frame(8'h01, 8'h91, 8'h92);
		send_frame(8'h00, 8'h01, 8'h01);

		// Random phases, each with its own register settings; the two after the directed
		// part sit at the opposite extremes of every register.
		for (phase_idx = 1; phase_idx <= MIXED_PHASES; phase_idx++) begin
			case (phase_idx)
				1: begin
					s.strict    = 1'b1;
					s.raw_mm    = 1'b1;
					s.empty_mm  = 5000;
					s.full_mm   = 0;
					s.offset_mm = -500;
					s.tol_mm    = 0;
					s.height_mm = 10000;
					s.capacity  = 100000;
				end
				2: begin
					s.strict    = 1'b0;
					s.raw_mm    = 1'b0;
					s.empty_mm  = 0;
					s.full_mm   = 5000;
					s.offset_mm = 500;
					s.tol_mm    = 500;
					s.height_mm = 1;
					s.capacity  = 1;
				end
				MIXED_PHASES: s = reset_settings();
				default: s = random_settings();
			endcase
			wait_idle();
			write_settings(s);
			if (phase_idx == HOLD_OFF_PHASE)
				hold_off_req = 1'b1;
			// last phase runs with both sides at full rate
			if (phase_idx == MIXED_PHASES)
				idling = 1'b0;
			run_mixed(MIXED_ITEMS, s);
		end

		// drain, then give a late or extra result time to show up
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_total == 0 && readings_due == 0)
			$display("ultrasonic_tank_level_gauge verification clean");
		else
			$display("ultrasonic_tank_level_gauge verification failed");
		$finish;
	end

endmodule
